/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL files of the rotation unit.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define RPA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a condition in the next cycle.
`define RPA_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

/* hdl/rpa_pkg.sv */
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and constants for the axis-angle point rotation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpa_pkg;

    // Number of CORDIC micro-rotations, one pipeline stage each (8 to 24).
    localparam int CORDIC_STAGES = 16;

    // Width of the CORDIC x, y and z datapath (Q2.30 with headroom).
    localparam int CW = 34;

    // Start value of x, the limit of the inverse CORDIC gain in Q2.30.
    localparam logic signed [CW-1:0] CORDIC_START = 34'sh026DD3B6A;

    // One in Q2.30.
    localparam logic signed [CW:0] ONE_Q30 = 35'sh040000000;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [32:0]   off_t;
    typedef logic signed [31:0]   coord_t;
    typedef logic signed [15:0]   axis_t;

    // Per-item data that travels beside the CORDIC pipeline.
    typedef struct packed {
        off_t   d_x;
        off_t   d_y;
        off_t   d_z;
        coord_t c_x;
        coord_t c_y;
        coord_t c_z;
        axis_t  a_x;
        axis_t  a_y;
        axis_t  a_z;
    } side_t;

    // Arctangent of 2^-i as a fraction of a turn, scaled by 2^32.
    function automatic cval_t atan_at(input int idx);
        cval_t v;
        unique case (idx)
            0:  v = 34'sh020000000;
            1:  v = 34'sh012E4051E;
            2:  v = 34'sh009FB385B;
            3:  v = 34'sh0051111D4;
            4:  v = 34'sh0028B0D43;
            5:  v = 34'sh00145D7E1;
            6:  v = 34'sh000A2F61E;
            7:  v = 34'sh000517C55;
            8:  v = 34'sh00028BE53;
            9:  v = 34'sh000145F2F;
            10: v = 34'sh0000A2F98;
            11: v = 34'sh0000517CC;
            12: v = 34'sh000028BE6;
            13: v = 34'sh0000145F3;
            14: v = 34'sh00000A2FA;
            15: v = 34'sh00000517D;
            16: v = 34'sh0000028BE;
            17: v = 34'sh00000145F;
            18: v = 34'sh000000A30;
            19: v = 34'sh000000518;
            20: v = 34'sh00000028C;
            21: v = 34'sh000000146;
            22: v = 34'sh0000000A3;
            23: v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/rpa_cordic.sv */
// ----------------------------------------------------------------------------
// rpa_cordic
// Pipelined rotation-mode CORDIC giving cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpa_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [15:0]           angle,
    output rpa_pkg::cval_t        cos_raw,
    output rpa_pkg::cval_t        sin_raw,
    output logic                  neg
);

    localparam int N = rpa_pkg::CORDIC_STAGES;

    rpa_pkg::cval_t x_reg [0:N];
    rpa_pkg::cval_t y_reg [0:N];
    rpa_pkg::cval_t z_reg [0:N];
    logic           neg_reg [0:N];

    rpa_pkg::cval_t x_next [0:N];
    rpa_pkg::cval_t y_next [0:N];
    rpa_pkg::cval_t z_next [0:N];

    logic [31:0]        u_raw;
    logic [31:0]        u_fold;
    logic signed [31:0] z_raw;
    logic               fold;

    // Fold angles beyond a quarter turn by half a turn.
    always_comb
    begin
        u_raw  = {angle, 16'h0000};
        z_raw  = $signed(u_raw);
        fold   = (z_raw > 32'sh40000000) || (z_raw < -32'sh40000000);
        u_fold = fold ? (u_raw ^ 32'h80000000) : u_raw;
        x_next[0] = rpa_pkg::CORDIC_START;
        y_next[0] = '0;
        z_next[0] = rpa_pkg::CW'($signed(u_fold));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= x_next[0];
            y_reg[0]   <= y_next[0];
            z_reg[0]   <= z_next[0];
            neg_reg[0] <= fold;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_comb
        begin
            if (!z_reg[i][rpa_pkg::CW-1])
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - rpa_pkg::atan_at(i);
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + rpa_pkg::atan_at(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]   <= x_next[i+1];
                y_reg[i+1]   <= y_next[i+1];
                z_reg[i+1]   <= z_next[i+1];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign cos_raw = x_reg[N];
    assign sin_raw = y_reg[N];
    assign neg     = neg_reg[N];

    // The folded start angle must lie within a quarter turn.
    `RPA_ASSERT(a_fold_range, (z_next[0] <= 34'sh040000000) && (z_next[0] >= -34'sh040000000), "folded angle out of range")

endmodule

/* hdl/rotate_point_about_axis_unit.sv */
// ----------------------------------------------------------------------------
// rotate_point_about_axis_unit
// Rotates a Q16.16 point about an axis through a center by a binary angle.
// ----------------------------------------------------------------------------
// The unit accepts one point per clock while the pipeline is not stalled and
// returns one rotated point per point, in order. The pipeline registers angle
// folding and the offset, then each CORDIC micro-rotation, then the fold undo
// with the axis outer products, the matrix terms, the matrix elements, the nine
// products, and the final sum with rounding, center add and saturation.
// A stall on the result side holds the whole pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rotate_point_about_axis_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    input  logic signed [31:0]  center_x,
    input  logic signed [31:0]  center_y,
    input  logic signed [31:0]  center_z,
    input  logic [15:0]         rotation_angle,
    input  logic signed [15:0]  axis_x,
    input  logic signed [15:0]  axis_y,
    input  logic signed [15:0]  axis_z,
    output logic                result_valid,
    input  logic                result_ready,
    output logic signed [31:0]  rotated_x,
    output logic signed [31:0]  rotated_y,
    output logic signed [31:0]  rotated_z
);

    localparam int N  = rpa_pkg::CORDIC_STAGES;
    localparam int L  = N + 6;
    localparam int SA = N + 1;
    localparam int SC = N + 3;
    localparam int SD = N + 4;

    logic en;
    logic [L-1:0] v_reg;
    rpa_pkg::side_t side_reg [0:L-2];
    rpa_pkg::side_t side_next;

    rpa_pkg::cval_t cos_raw;
    rpa_pkg::cval_t sin_raw;
    logic           neg;

    // Pipeline advances whenever the output stage is empty or being taken.
    assign en           = !v_reg[L-1] || result_ready;
    assign item_ready   = en;
    assign result_valid = v_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[L-2:0], item_valid};
        end
    end

    // Offsets, centers and axis travel beside the CORDIC.
    always_comb
    begin
        side_next.d_x = 33'(point_x) - 33'(center_x);
        side_next.d_y = 33'(point_y) - 33'(center_y);
        side_next.d_z = 33'(point_z) - 33'(center_z);
        side_next.c_x = center_x;
        side_next.c_y = center_y;
        side_next.c_z = center_z;
        side_next.a_x = axis_x;
        side_next.a_y = axis_y;
        side_next.a_z = axis_z;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int j = 1; j < L - 1; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    rpa_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .angle   (rotation_angle),
        .cos_raw (cos_raw),
        .sin_raw (sin_raw),
        .neg     (neg)
    );

    // Stage A: undo the fold and form the axis outer products.
    rpa_pkg::cval_t     c_reg, s_reg, c_next, s_next;
    logic signed [31:0] p_reg [3][3];
    logic signed [31:0] p_next [3][3];
    rpa_pkg::axis_t     a_n [3];

    always_comb
    begin
        a_n[0] = side_reg[N].a_x;
        a_n[1] = side_reg[N].a_y;
        a_n[2] = side_reg[N].a_z;
        c_next = neg ? -cos_raw : cos_raw;
        s_next = neg ? -sin_raw : sin_raw;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p_next[r][k] = 32'(a_n[r]) * 32'(a_n[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg  <= c_next;
            s_reg  <= s_next;
            p_reg  <= p_next;
        end
    end

    // Stage B: scale by 1 - c and s, rounded to 22 fraction bits.
    logic signed [31:0] tp_reg [3][3];
    logic signed [31:0] tp_next [3][3];
    logic signed [31:0] sa_reg [3];
    logic signed [31:0] sa_next [3];
    logic signed [31:0] cq_reg, cq_next;
    logic signed [34:0] t_val;
    logic signed [34:0] cq_sum;
    logic signed [66:0] tp_full [3][3];
    logic signed [49:0] sa_full [3];
    rpa_pkg::axis_t     a_b [3];

    always_comb
    begin
        a_b[0] = side_reg[SA].a_x;
        a_b[1] = side_reg[SA].a_y;
        a_b[2] = side_reg[SA].a_z;
        t_val  = rpa_pkg::ONE_Q30 - 35'(c_reg);
        cq_sum = (35'(c_reg) + 35'sd128) >>> 8;
        cq_next = cq_sum[31:0];
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                tp_full[r][k] = ((67'(t_val) * 67'(p_reg[r][k])) + (67'sd1 <<< 35)) >>> 36;
                tp_next[r][k] = tp_full[r][k][31:0];
            end
            sa_full[r] = ((50'(s_reg) * 50'(a_b[r])) + (50'sd1 <<< 21)) >>> 22;
            sa_next[r] = sa_full[r][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tp_reg <= tp_next;
            sa_reg <= sa_next;
            cq_reg <= cq_next;
        end
    end

    // Stage C: matrix elements c*I + (1-c)*a*a^T + s*[a]x.
    logic signed [31:0] m_reg [3][3];
    logic signed [31:0] m_next [3][3];

    always_comb
    begin
        m_next[0][0] = tp_reg[0][0] + cq_reg;
        m_next[0][1] = tp_reg[0][1] - sa_reg[2];
        m_next[0][2] = tp_reg[0][2] + sa_reg[1];
        m_next[1][0] = tp_reg[1][0] + sa_reg[2];
        m_next[1][1] = tp_reg[1][1] + cq_reg;
        m_next[1][2] = tp_reg[1][2] - sa_reg[0];
        m_next[2][0] = tp_reg[2][0] - sa_reg[1];
        m_next[2][1] = tp_reg[2][1] + sa_reg[0];
        m_next[2][2] = tp_reg[2][2] + cq_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m_next;
        end
    end

    // Stage D: element times offset products.
    logic signed [64:0] md_reg [3][3];
    logic signed [64:0] md_next [3][3];
    rpa_pkg::off_t      d_c [3];

    always_comb
    begin
        d_c[0] = side_reg[SC].d_x;
        d_c[1] = side_reg[SC].d_y;
        d_c[2] = side_reg[SC].d_z;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                md_next[r][k] = 65'(m_reg[r][k]) * 65'(d_c[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            md_reg <= md_next;
        end
    end

    // Stage E: row sums, rounding back to Q16.16, center add, saturation.
    logic signed [31:0] out_reg [3];
    logic signed [31:0] out_next [3];
    logic signed [66:0] acc [3];
    logic signed [46:0] sum [3];
    rpa_pkg::coord_t    ctr_d [3];

    always_comb
    begin
        ctr_d[0] = side_reg[SD].c_x;
        ctr_d[1] = side_reg[SD].c_y;
        ctr_d[2] = side_reg[SD].c_z;
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = (67'(md_reg[r][0]) + 67'(md_reg[r][1]) + 67'(md_reg[r][2])
                      + (67'sd1 <<< 21)) >>> 22;
            sum[r] = 47'(acc[r]) + 47'(ctr_d[r]);
            if (sum[r] > 47'sh7FFFFFFF)
            begin
                out_next[r] = 32'sh7FFFFFFF;
            end
            else if (sum[r] < -47'sh80000000)
            begin
                out_next[r] = 32'sh80000000;
            end
            else
            begin
                out_next[r] = sum[r][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign rotated_x = out_reg[0];
    assign rotated_y = out_reg[1];
    assign rotated_z = out_reg[2];

    // Valid bits shift one stage on each advance and hold on a stall.
    `RPA_ASSERT_NEXT(a_valid_shift, en, v_reg[L-1:1] == $past(v_reg[L-2:0]), "valid bits did not shift")
    `RPA_ASSERT_NEXT(a_valid_hold, !en, $stable(v_reg), "valid bits changed during stall")
    `RPA_ASSERT_NEXT(a_accept_enters, item_valid && item_ready, v_reg[0], "accepted item lost at entry")

endmodule
